### sv/mscell_pkg.sv
// Shared types, constants and the crossing table for the marching squares cell.
`timescale 1ns / 1ps
`default_nettype none

package mscell_pkg;

  // Cell column and row indexes are 10 bits wide.
  localparam int POS_BITS = 10;

  localparam int GRID_SIZE_DEF   = 1024;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Edge codes; bit n of a crossing mask stands for the edge with code n.
  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  // How the vertex is placed on its edge.
  typedef enum logic [1:0] {
    SNAP_NONE  = 2'd0,
    SNAP_START = 2'd1,
    SNAP_END   = 2'd2
  } snap_t;

  // Control that travels with one vertex down the pipeline.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                axis_y;
    logic                dec;
    snap_t               snap;
    logic [POS_BITS:0]   x1;
    logic [POS_BITS:0]   y1;
  } vtx_ctl_t;

  // Crossed edges for each inside pattern. The saddles map to no edges.
  function automatic logic [3:0] cross_edges(input logic [3:0] idx);
    logic [3:0] m;
    unique case (idx)
      4'h0:    m = 4'h0;
      4'h1:    m = 4'h9;
      4'h2:    m = 4'h3;
      4'h3:    m = 4'ha;
      4'h4:    m = 4'h6;
      4'h5:    m = 4'h0;
      4'h6:    m = 4'h5;
      4'h7:    m = 4'hc;
      4'h8:    m = 4'hc;
      4'h9:    m = 4'h5;
      4'ha:    m = 4'h0;
      4'hb:    m = 4'h6;
      4'hc:    m = 4'ha;
      4'hd:    m = 4'h3;
      4'he:    m = 4'h9;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### sv/mscell_div.sv
// Pipelined restoring divider that produces the fractional edge position.
`timescale 1ns / 1ps
`default_nettype none

module mscell_div #(
  parameter int SAMPLE_BITS = mscell_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = mscell_pkg::FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mscell_pkg::vtx_ctl_t   in_ctl,
  input  wire logic [SAMPLE_BITS-1:0] in_num,
  input  wire logic [SAMPLE_BITS-1:0] in_den,
  output mscell_pkg::vtx_ctl_t        out_ctl,
  output logic [FRAC_BITS-1:0]        out_quo
);

  // Two quotient bits are resolved in each stage, and one in the last stage when FRAC_BITS is odd.
  localparam int NSTG = (FRAC_BITS + 1) / 2;

  mscell_pkg::vtx_ctl_t   ctl_r [NSTG];
  logic [SAMPLE_BITS-1:0] rem_r [NSTG];
  logic [SAMPLE_BITS-1:0] den_r [NSTG];
  logic [FRAC_BITS-1:0]   quo_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int NB = ((FRAC_BITS - 2 * s) >= 2) ? 2 : 1;

    mscell_pkg::vtx_ctl_t   ctl_in;
    logic [SAMPLE_BITS-1:0] rem_in;
    logic [SAMPLE_BITS-1:0] den_in;
    logic [FRAC_BITS-1:0]   quo_in;
    logic [SAMPLE_BITS-1:0] rem_nxt;
    logic [FRAC_BITS-1:0]   quo_nxt;

    if (s == 0) begin : g_first
      assign ctl_in = in_ctl;
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_r[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      logic [SAMPLE_BITS:0] sh;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int k = 0; k < NB; k++) begin
        sh = {rem_nxt, 1'b0};
        if (sh >= {1'b0, den_in}) begin
          sh      = sh - {1'b0, den_in};
          quo_nxt = {quo_nxt[FRAC_BITS-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[FRAC_BITS-2:0], 1'b0};
        end
        rem_nxt = sh[SAMPLE_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else begin
        ctl_r[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_in;
      quo_r[s] <= quo_nxt;
    end
  end

  assign out_ctl = ctl_r[NSTG-1];
  assign out_quo = quo_r[NSTG-1];

endmodule

`default_nettype wire

### sv/marching_squares_cell.sv
// The first vertex strobes out_valid after the mask register and the pipeline stages below,
// the second in the next cycle. One vertex leaves the edge pipeline per cycle, so a cell with a
// crossing holds busy until only its last edge is left; a cell with no crossing leaves busy low.
// The pipeline is a select stage, a difference stage, (FRAC_BITS+1)/2 divider stages and an
// output stage. Synchronous reset clears all valid bits and sets the iso level to 0.
`timescale 1ns / 1ps
`default_nettype none

module marching_squares_cell #(
  parameter int GRID_SIZE   = mscell_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS   = mscell_pkg::FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = mscell_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       start,
  output logic                                            busy,
  input  wire logic [mscell_pkg::POS_BITS-1:0]            in_cell_col,
  input  wire logic [mscell_pkg::POS_BITS-1:0]            in_cell_row,
  input  wire logic signed [SAMPLE_BITS-1:0]              in_corner_top_left,
  input  wire logic signed [SAMPLE_BITS-1:0]              in_corner_top_right,
  input  wire logic signed [SAMPLE_BITS-1:0]              in_corner_bottom_right,
  input  wire logic signed [SAMPLE_BITS-1:0]              in_corner_bottom_left,
  output logic                                            out_valid,
  output logic [mscell_pkg::POS_BITS+FRAC_BITS-1:0]       out_vert_x_fixed,
  output logic [mscell_pkg::POS_BITS+FRAC_BITS-1:0]       out_vert_y_fixed,
  output logic                                            out_last_vertex,
  input  wire logic                                       cfg_valid,
  output logic                                            cfg_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]              cfg_iso_level
);

  localparam int PB    = mscell_pkg::POS_BITS;
  localparam int OUTW  = PB + FRAC_BITS;
  localparam int GRIDW = $clog2(GRID_SIZE + 1);
  localparam int CW    = ((GRIDW > PB + 1) ? GRIDW : PB + 1) + FRAC_BITS;
  localparam logic [CW-1:0] COORD_MAX = (CW'(GRID_SIZE) << FRAC_BITS) - CW'(1);

  // Configuration register.
  logic signed [SAMPLE_BITS-1:0] iso_level_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_level_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      iso_level_r <= cfg_iso_level;
    end
  end

  // Cell hold register and the mask of edges still to issue.
  logic [PB-1:0]                 col_r, row_r;
  logic signed [SAMPLE_BITS-1:0] tl_r, tr_r, br_r, bl_r;
  logic [3:0]                    mask_r;
  logic [3:0]                    mask_rest;
  logic [3:0]                    case_idx;
  logic                          accept;

  assign mask_rest = mask_r & (mask_r - 4'd1);
  assign busy      = (mask_rest != 4'd0);
  assign accept    = start && !busy;

  assign case_idx = {in_corner_bottom_left  < iso_level_r,
                     in_corner_bottom_right < iso_level_r,
                     in_corner_top_right    < iso_level_r,
                     in_corner_top_left     < iso_level_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (accept) begin
      mask_r <= mscell_pkg::cross_edges(case_idx);
    end else begin
      mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_cell_col;
      row_r <= in_cell_row;
      tl_r  <= in_corner_top_left;
      tr_r  <= in_corner_top_right;
      br_r  <= in_corner_bottom_right;
      bl_r  <= in_corner_bottom_left;
    end
  end

  // Select stage: the lowest pending edge is issued each cycle.
  mscell_pkg::edge_t             edge_sel;
  mscell_pkg::vtx_ctl_t          a_ctl_nxt, a_ctl_r;
  logic [SAMPLE_BITS-1:0]        a_v1_nxt, a_v2_nxt, a_v1_r, a_v2_r;
  logic [PB:0]                   col_x, col_x1, row_y, row_y1;

  assign col_x  = {1'b0, col_r};
  assign col_x1 = {1'b0, col_r} + (PB+1)'(1);
  assign row_y  = {1'b0, row_r};
  assign row_y1 = {1'b0, row_r} + (PB+1)'(1);

  always_comb begin
    if (mask_r[0]) begin
      edge_sel = mscell_pkg::EDGE_TOP;
    end else if (mask_r[1]) begin
      edge_sel = mscell_pkg::EDGE_RIGHT;
    end else if (mask_r[2]) begin
      edge_sel = mscell_pkg::EDGE_BOTTOM;
    end else begin
      edge_sel = mscell_pkg::EDGE_LEFT;
    end

    a_ctl_nxt.valid = (mask_r != 4'd0);
    a_ctl_nxt.last  = (mask_rest == 4'd0);
    a_ctl_nxt.snap  = mscell_pkg::SNAP_NONE;

    case (edge_sel)
      mscell_pkg::EDGE_TOP: begin
        a_v1_nxt         = tl_r;
        a_v2_nxt         = tr_r;
        a_ctl_nxt.x1     = col_x;
        a_ctl_nxt.y1     = row_y;
        a_ctl_nxt.axis_y = 1'b0;
        a_ctl_nxt.dec    = 1'b0;
      end
      mscell_pkg::EDGE_RIGHT: begin
        a_v1_nxt         = tr_r;
        a_v2_nxt         = br_r;
        a_ctl_nxt.x1     = col_x1;
        a_ctl_nxt.y1     = row_y;
        a_ctl_nxt.axis_y = 1'b1;
        a_ctl_nxt.dec    = 1'b0;
      end
      mscell_pkg::EDGE_BOTTOM: begin
        a_v1_nxt         = br_r;
        a_v2_nxt         = bl_r;
        a_ctl_nxt.x1     = col_x1;
        a_ctl_nxt.y1     = row_y1;
        a_ctl_nxt.axis_y = 1'b0;
        a_ctl_nxt.dec    = 1'b1;
      end
      default: begin
        a_v1_nxt         = bl_r;
        a_v2_nxt         = tl_r;
        a_ctl_nxt.x1     = col_x;
        a_ctl_nxt.y1     = row_y1;
        a_ctl_nxt.axis_y = 1'b1;
        a_ctl_nxt.dec    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else begin
      a_ctl_r <= a_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_v1_r <= a_v1_nxt;
    a_v2_r <= a_v2_nxt;
  end

  // Difference stage: snap decision, numerator and denominator magnitudes.
  mscell_pkg::vtx_ctl_t   b_ctl_nxt, b_ctl_r;
  logic [SAMPLE_BITS:0]   d_num, d_den;
  logic [SAMPLE_BITS:0]   abs_num, abs_den;
  logic [SAMPLE_BITS-1:0] b_num_r, b_den_r;
  logic                   iso_eq_v1, iso_eq_v2, v1_eq_v2;

  assign iso_eq_v1 = (iso_level_r == a_v1_r);
  assign iso_eq_v2 = (iso_level_r == a_v2_r);
  assign v1_eq_v2  = (a_v1_r == a_v2_r);

  assign d_num   = {iso_level_r[SAMPLE_BITS-1], iso_level_r} - {a_v1_r[SAMPLE_BITS-1], a_v1_r};
  assign d_den   = {a_v2_r[SAMPLE_BITS-1], a_v2_r} - {a_v1_r[SAMPLE_BITS-1], a_v1_r};
  assign abs_num = d_num[SAMPLE_BITS] ? -d_num : d_num;
  assign abs_den = d_den[SAMPLE_BITS] ? -d_den : d_den;

  always_comb begin
    b_ctl_nxt = a_ctl_r;
    if (iso_eq_v1 || (!iso_eq_v2 && v1_eq_v2)) begin
      b_ctl_nxt.snap = mscell_pkg::SNAP_START;
    end else if (iso_eq_v2) begin
      b_ctl_nxt.snap = mscell_pkg::SNAP_END;
    end else begin
      b_ctl_nxt.snap = mscell_pkg::SNAP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else begin
      b_ctl_r <= b_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_num_r <= abs_num[SAMPLE_BITS-1:0];
    b_den_r <= abs_den[SAMPLE_BITS-1:0];
  end

  // Divider stages.
  mscell_pkg::vtx_ctl_t d_ctl;
  logic [FRAC_BITS-1:0] d_quo;

  mscell_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (b_ctl_r),
    .in_num  (b_num_r),
    .in_den  (b_den_r),
    .out_ctl (d_ctl),
    .out_quo (d_quo)
  );

  // Output stage: place the vertex and saturate at the grid edge.
  logic [FRAC_BITS:0] frac;
  logic [CW-1:0]      base_x, base_y, pos_x, pos_y, sat_x, sat_y;
  logic               out_valid_r, out_last_r;
  logic [OUTW-1:0]    out_x_r, out_y_r;

  always_comb begin
    case (d_ctl.snap)
      mscell_pkg::SNAP_START: frac = '0;
      mscell_pkg::SNAP_END:   frac = (FRAC_BITS+1)'(1) << FRAC_BITS;
      default:                frac = {1'b0, d_quo};
    endcase

    base_x = CW'(d_ctl.x1) << FRAC_BITS;
    base_y = CW'(d_ctl.y1) << FRAC_BITS;
    pos_x  = base_x;
    pos_y  = base_y;
    if (d_ctl.axis_y) begin
      pos_y = d_ctl.dec ? base_y - CW'(frac) : base_y + CW'(frac);
    end else begin
      pos_x = d_ctl.dec ? base_x - CW'(frac) : base_x + CW'(frac);
    end
    sat_x = (pos_x > COORD_MAX) ? COORD_MAX : pos_x;
    sat_y = (pos_y > COORD_MAX) ? COORD_MAX : pos_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r    <= sat_x[OUTW-1:0];
    out_y_r    <= sat_y[OUTW-1:0];
    out_last_r <= d_ctl.last;
  end

  assign out_valid        = out_valid_r;
  assign out_vert_x_fixed = out_x_r;
  assign out_vert_y_fixed = out_y_r;
  assign out_last_vertex  = out_last_r;

endmodule

`default_nettype wire
